// File: sv/lbpg_pkg.sv
package lbpg_pkg;

  localparam int MODE_W = 3;
  localparam int CMD_W  = 2;
  localparam int IVL_W  = 8;
  localparam int SOS_W  = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STATUS = 2'd2;

  localparam logic [MODE_W-1:0] PAT_OFF    = 3'd0;
  localparam logic [MODE_W-1:0] PAT_ON     = 3'd1;
  localparam logic [MODE_W-1:0] PAT_NORMAL = 3'd2;
  localparam logic [MODE_W-1:0] PAT_FAST   = 3'd3;
  localparam logic [MODE_W-1:0] PAT_SLOW   = 3'd4;
  localparam logic [MODE_W-1:0] PAT_SOS    = 3'd5;
  localparam logic [MODE_W-1:0] PAT_ALARM  = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM  = 2'd3;

  localparam logic [IVL_W-1:0] NORMAL_RST = 8'd12;
  localparam logic [IVL_W-1:0] FAST_RST   = 8'd4;
  localparam logic [IVL_W-1:0] SLOW_RST   = 8'd28;
  localparam logic [IVL_W-1:0] ALARM_RST  = 8'd8;

  localparam logic [SOS_W-1:0] SOS_LAST = 5'd17;

  typedef struct packed {
    logic [IVL_W-1:0] normal_ticks;
    logic [IVL_W-1:0] fast_ticks;
    logic [IVL_W-1:0] slow_ticks;
    logic [IVL_W-1:0] alarm_ticks;
  } lbpg_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              led;
    logic              buzzer;
    logic [SOS_W-1:0]  sos_idx;
  } lbpg_state_t;

  // Morse SOS step lengths in ticks; out-of-range steps read as step zero
  function automatic logic [IVL_W-1:0] sos_ticks(input logic [SOS_W-1:0] idx);
    logic [IVL_W-1:0] t;
    case (idx)
      5'd5, 5'd6, 5'd8, 5'd10, 5'd11: t = 8'd12;
      5'd17:                          t = 8'd36;
      default:                        t = 8'd4;
    endcase
    return t;
  endfunction

endpackage

// File: sv/lbpg_core.sv
module lbpg_core
  import lbpg_pkg::*;
#(
  parameter int COUNT_WIDTH = 8
) (
  input  logic [CMD_W-1:0]       command,
  input  logic [MODE_W-1:0]      mode_req,
  input  lbpg_cfg_t              cfg,
  input  lbpg_state_t            st,
  input  logic [COUNT_WIDTH-1:0] elapsed,
  output lbpg_state_t            st_nxt,
  output logic [COUNT_WIDTH-1:0] elapsed_nxt
);

  localparam int CMP_W = (COUNT_WIDTH > IVL_W) ? COUNT_WIDTH : IVL_W;

  logic [CMP_W-1:0]       el_cmp;
  logic [IVL_W-1:0]       ivl;
  logic                   reached;
  logic [SOS_W-1:0]       idx;
  logic [COUNT_WIDTH-1:0] el_work;

  assign el_cmp = CMP_W'(elapsed);
  assign idx    = (st.sos_idx > SOS_LAST) ? '0 : st.sos_idx;

  always_comb begin
    case (st.mode)
      PAT_NORMAL: ivl = cfg.normal_ticks;
      PAT_FAST:   ivl = cfg.fast_ticks;
      PAT_SLOW:   ivl = cfg.slow_ticks;
      PAT_ALARM:  ivl = cfg.alarm_ticks;
      PAT_SOS:    ivl = sos_ticks(idx);
      default:    ivl = '0;
    endcase
  end

  assign reached = (el_cmp >= CMP_W'(ivl));

  always_comb begin
    st_nxt      = st;
    elapsed_nxt = elapsed;
    el_work     = elapsed;
    case (command)
      CMD_TICK: begin
        case (st.mode)
          PAT_ON: begin
            st_nxt.led    = 1'b1;
            st_nxt.buzzer = 1'b0;
          end
          PAT_NORMAL, PAT_FAST, PAT_SLOW: begin
            st_nxt.buzzer = 1'b0;
            if (reached) begin
              st_nxt.led = ~st.led;
              el_work    = '0;
            end
          end
          PAT_SOS: begin
            st_nxt.sos_idx = idx;
            if (reached) begin
              // even steps sound, odd steps are gaps
              st_nxt.led     = ~idx[0];
              st_nxt.buzzer  = ~idx[0];
              st_nxt.sos_idx = (idx == SOS_LAST) ? '0 : idx + 1'b1;
              el_work        = '0;
            end
          end
          PAT_ALARM: begin
            if (reached) begin
              st_nxt.led    = ~st.led;
              st_nxt.buzzer = ~st.led;
              el_work       = '0;
            end
          end
          default: begin
            st_nxt.mode   = PAT_OFF;
            st_nxt.led    = 1'b0;
            st_nxt.buzzer = 1'b0;
          end
        endcase
        // saturate at all ones
        elapsed_nxt = (&el_work) ? el_work : el_work + 1'b1;
      end
      CMD_SET: begin
        if (mode_req <= PAT_ALARM) begin
          st_nxt.mode    = mode_req;
          st_nxt.led     = 1'b0;
          st_nxt.buzzer  = 1'b0;
          st_nxt.sos_idx = '0;
          elapsed_nxt    = '0;
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

endmodule

// File: sv/led_buzzer_pattern_generator_unit.sv
// Channel | Direction | Ports                                          | Accepted when
// in      | input     | in_command, in_new_mode                        | in_valid & in_ready
// out     | output    | out_led_out, out_buzzer_out, out_mode_out      | out_valid & out_ready
// cfg     | input     | cfg_index, cfg_data                            | cfg_valid & cfg_ready
//
// One item per clock while the result side is not stalled: an item is captured in
// the input register, then the mode logic updates the state and loads the result
// register.
// Reset (rst_n low, synchronous) sets mode off, both outputs low, counters zero
// and the interval registers to their defaults. cfg_ready is always high.
// A stalled result holds both stages; in_ready drops only when both are full.
module led_buzzer_pattern_generator_unit
  import lbpg_pkg::*;
#(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [MODE_W-1:0]    in_new_mode,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_led_out,
  output logic                 out_buzzer_out,
  output logic [MODE_W-1:0]    out_mode_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [IVL_W-1:0]     cfg_data
);

  lbpg_cfg_t              cfg_r;
  lbpg_state_t            st_r, st_nxt;
  logic [COUNT_WIDTH-1:0] elapsed_r, elapsed_nxt;

  logic                   s1_valid_r;
  logic [CMD_W-1:0]       s1_cmd_r;
  logic [MODE_W-1:0]      s1_mode_r;
  logic                   out_valid_r;
  logic                   s2_adv;

  assign cfg_ready = 1'b1;
  assign s2_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s2_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.normal_ticks <= NORMAL_RST;
      cfg_r.fast_ticks   <= FAST_RST;
      cfg_r.slow_ticks   <= SLOW_RST;
      cfg_r.alarm_ticks  <= ALARM_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NORMAL: cfg_r.normal_ticks <= cfg_data;
        REG_FAST:   cfg_r.fast_ticks   <= cfg_data;
        REG_SLOW:   cfg_r.slow_ticks   <= cfg_data;
        REG_ALARM:  cfg_r.alarm_ticks  <= cfg_data;
        default:    cfg_r              <= cfg_r;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r  <= in_command;
      s1_mode_r <= in_new_mode;
    end
  end

  lbpg_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .command    (s1_cmd_r),
    .mode_req   (s1_mode_r),
    .cfg        (cfg_r),
    .st         (st_r),
    .elapsed    (elapsed_r),
    .st_nxt     (st_nxt),
    .elapsed_nxt(elapsed_nxt)
  );

  // state and result register advance together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_adv) begin
        st_r      <= st_nxt;
        elapsed_r <= elapsed_nxt;
      end
      if (s2_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_out    = st_r.led;
  assign out_buzzer_out = st_r.buzzer;
  assign out_mode_out   = st_r.mode;

endmodule

// File: sim/tb_led_buzzer_pattern_generator_unit.sv
`timescale 1ns / 100ps

module tb_led_buzzer_pattern_generator_unit;
  import lbpg_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_CYCLES = 80;

  // codes the package leaves unnamed
  localparam logic [CMD_W-1:0]  CMD_SPARE  = 2'd3;
  localparam logic [MODE_W-1:0] PAT_UNUSED = 3'd7;

  // SOS step lengths, step zero in the low byte
  localparam logic [18*IVL_W-1:0] SOS_STEP_TICKS = {
    8'd36, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4,
    8'd12, 8'd12, 8'd4, 8'd12, 8'd4, 8'd12,
    8'd12, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4
  };

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [MODE_W-1:0] mode_req;
  } led_cmd_t;

  typedef struct packed {
    logic              led;
    logic              buzzer;
    logic [MODE_W-1:0] mode;
  } pattern_levels_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_command = CMD_STATUS;
  logic [MODE_W-1:0]    in_new_mode = PAT_OFF;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_led_out;
  logic                 out_buzzer_out;
  logic [MODE_W-1:0]    out_mode_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_NORMAL;
  logic [IVL_W-1:0]     cfg_data = '0;

  led_cmd_t        cmd_backlog[$];
  pattern_levels_t levels_due[$];

  int   idle_pct = 6;
  int   cycle_count = 0;
  int   mismatch_count = 0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   stall_left = 0;
  logic in_fired = 1'b0;

  // predictor copy of the pattern state and interval registers
  logic [IVL_W-1:0]  ivl_normal = NORMAL_RST;
  logic [IVL_W-1:0]  ivl_fast   = FAST_RST;
  logic [IVL_W-1:0]  ivl_slow   = SLOW_RST;
  logic [IVL_W-1:0]  ivl_alarm  = ALARM_RST;
  logic [MODE_W-1:0] cur_mode   = PAT_OFF;
  logic              cur_led    = 1'b0;
  logic              cur_buzzer = 1'b0;
  logic [7:0]        tick_cnt   = '0;
  int                sos_pos    = 0;

  led_buzzer_pattern_generator_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_new_mode    (in_new_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_led_out    (out_led_out),
    .out_buzzer_out (out_buzzer_out),
    .out_mode_out   (out_mode_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  task automatic blink_toggle(input logic [IVL_W-1:0] interval);
    cur_buzzer = 1'b0;
    if (tick_cnt >= interval) begin
      cur_led = ~cur_led;
      tick_cnt = '0;
    end
  endtask

  // apply one item to the predicted state and queue the levels it leaves
  task automatic advance_pattern(input logic [CMD_W-1:0] command,
                                 input logic [MODE_W-1:0] mode_req);
    pattern_levels_t lv;
    if (command == CMD_TICK) begin
      case (cur_mode)
        PAT_ON: begin
          cur_led = 1'b1;
          cur_buzzer = 1'b0;
        end
        PAT_NORMAL: blink_toggle(ivl_normal);
        PAT_FAST:   blink_toggle(ivl_fast);
        PAT_SLOW:   blink_toggle(ivl_slow);
        PAT_SOS: begin
          if (tick_cnt >= SOS_STEP_TICKS[sos_pos*IVL_W +: IVL_W]) begin
            cur_led = (sos_pos % 2 == 0);
            cur_buzzer = cur_led;
            sos_pos = (sos_pos == SOS_LAST) ? 0 : sos_pos + 1;
            tick_cnt = '0;
          end
        end
        PAT_ALARM: begin
          if (tick_cnt >= ivl_alarm) begin
            cur_led = ~cur_led;
            cur_buzzer = cur_led;
            tick_cnt = '0;
          end
        end
        default: begin
          cur_mode = PAT_OFF;
          cur_led = 1'b0;
          cur_buzzer = 1'b0;
        end
      endcase
      if (tick_cnt != 8'hFF) tick_cnt = tick_cnt + 1'b1;
    end else if (command == CMD_SET && mode_req != PAT_UNUSED) begin
      cur_mode = mode_req;
      cur_led = 1'b0;
      cur_buzzer = 1'b0;
      tick_cnt = '0;
      sos_pos = 0;
    end
    lv.led = cur_led;
    lv.buzzer = cur_buzzer;
    lv.mode = cur_mode;
    levels_due.push_back(lv);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // predictor and result check
  always @(posedge clk) begin : watch_blk
    pattern_levels_t want;
    in_fired <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NORMAL: ivl_normal = cfg_data;
          REG_FAST:   ivl_fast = cfg_data;
          REG_SLOW:   ivl_slow = cfg_data;
          REG_ALARM:  ivl_alarm = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) advance_pattern(in_command, in_new_mode);
      if (out_valid && out_ready) begin
        if (levels_due.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = levels_due.pop_front();
          if (out_led_out !== want.led)
            report_mismatch($sformatf("led %b, want %b", out_led_out, want.led));
          if (out_buzzer_out !== want.buzzer)
            report_mismatch($sformatf("buzzer %b, want %b", out_buzzer_out, want.buzzer));
          if (out_mode_out !== want.mode)
            report_mismatch($sformatf("mode %0d, want %0d", out_mode_out, want.mode));
        end
      end
    end
  end

  // sender: hold the item until taken, then offer the next one or idle
  always @(negedge clk) begin : send_blk
    led_cmd_t nxt;
    if (rst_n && (!in_valid || in_fired)) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = cmd_backlog.pop_front();
        in_valid <= 1'b1;
        in_command <= nxt.command;
        in_new_mode <= nxt.mode_req;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      stall_left <= STALL_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic push_item(input logic [CMD_W-1:0] command,
                           input logic [MODE_W-1:0] mode_req);
    led_cmd_t it;
    it.command = command;
    it.mode_req = mode_req;
    cmd_backlog.push_back(it);
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_item(CMD_TICK, MODE_W'($urandom_range(7)));
  endtask

  // mode changes followed by runs of ticks, with queries and some noise
  task automatic push_sequences(input int count, input int max_run);
    int made;
    int run;
    int pick;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        push_item(CMD_SPARE, MODE_W'($urandom_range(7)));
        made++;
      end else if (pick < 10) begin
        push_item(CMD_SET, PAT_UNUSED);
        made++;
      end else begin
        push_item(CMD_SET, MODE_W'($urandom_range(PAT_ALARM)));
        made++;
        run = $urandom_range(max_run, 1);
        repeat (run) begin
          push_item(($urandom_range(9) == 0) ? CMD_STATUS : CMD_TICK,
                    MODE_W'($urandom_range(7)));
          made++;
        end
      end
    end
  endtask

  task automatic write_intervals(input logic [IVL_W-1:0] v_normal,
                                 input logic [IVL_W-1:0] v_fast,
                                 input logic [IVL_W-1:0] v_slow,
                                 input logic [IVL_W-1:0] v_alarm);
    logic [IVL_W-1:0] vals[4];
    vals[0] = v_normal;
    vals[1] = v_fast;
    vals[2] = v_slow;
    vals[3] = v_alarm;
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || levels_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset intervals: query, unused codes, every mode
    push_item(CMD_STATUS, PAT_OFF);
    push_item(CMD_SPARE, PAT_UNUSED);
    push_item(CMD_TICK, PAT_SOS);
    push_item(CMD_SET, PAT_ON);
    push_item(CMD_TICK, PAT_OFF);
    push_item(CMD_SET, PAT_UNUSED);
    push_item(CMD_STATUS, PAT_ALARM);
    push_item(CMD_SET, PAT_NORMAL);
    push_item(CMD_TICK, PAT_FAST);
    push_item(CMD_SET, PAT_SLOW);
    push_item(CMD_TICK, PAT_ON);
    push_item(CMD_SET, PAT_OFF);
    push_item(CMD_TICK, PAT_UNUSED);
    push_item(CMD_SET, PAT_FAST);
    push_ticks(5);
    push_item(CMD_SET, PAT_ALARM);
    push_item(CMD_TICK, PAT_NORMAL);
    push_item(CMD_SET, PAT_SOS);
    push_ticks(3);
    push_sequences(80, 40);
    // stall the result side while items keep coming
    hold_req = hold_req + 1;
    wait_idle();

    // zero intervals: the blink and alarm patterns act on every tick
    write_intervals(8'd0, 8'd0, 8'd0, 8'd0);
    push_sequences(100, 12);
    wait_idle();

    // widest intervals
    write_intervals(8'd255, 8'd255, 8'd255, 8'd255);
    push_item(CMD_SET, PAT_NORMAL);
    push_ticks(260);
    push_sequences(40, 100);
    wait_idle();

    // short intervals, back to back with no idling
    idle_pct = 0;
    write_intervals(IVL_W'($urandom_range(6, 1)), IVL_W'($urandom_range(6, 1)),
                    IVL_W'($urandom_range(6, 1)), IVL_W'($urandom_range(6, 1)));
    push_sequences(80, 30);
    wait_idle();
    idle_pct = 6;

    write_intervals(IVL_W'($urandom_range(63)), IVL_W'($urandom_range(63)),
                    IVL_W'($urandom_range(63)), IVL_W'($urandom_range(63)));
    push_sequences(60, 60);
    wait_idle();

    if (mismatch_count == 0 && levels_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
